@@ sv/fpi_pkg.sv @@
// shared constants of the footstep pose integrator
`default_nettype none

package fpi_pkg;

	// pose position width, signed with 16 fraction bits
	localparam int POS_WIDTH = 24;

	localparam int ACT_W  = 16;
	localparam int YAW_W  = 16;
	localparam int TURN_W = 15;

	// world step after rounding, and the pose sum before saturation
	localparam int WX_W  = 20;
	localparam int SUM_W = ((POS_WIDTH > WX_W) ? POS_WIDTH : WX_W) + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ACTION_SCALE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FEET_SPACING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FORWARD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_BACKWARD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LEFT     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_RIGHT    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_TURN     = 3'd6;

	// digit-serial multiplier
	localparam int DIGIT_W    = 4;
	localparam int MUL_A_W    = 23;
	localparam int MUL_B_W    = 24;
	localparam int MUL_DIGITS = MUL_B_W / DIGIT_W;
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

	// sine polynomial, q14
	localparam logic [14:0] Q14_ONE = 15'd16384;
	localparam logic [14:0] SIN_A   = 15'd25736;
	localparam logic [14:0] SIN_B   = 15'd10512;
	localparam logic [14:0] SIN_C   = 15'd1160;

	// round(2^24 / (2*pi))
	localparam logic [21:0] INV_TWO_PI_Q24 = 22'd2670177;

endpackage

`default_nettype wire

@@ sv/footstep_pose_integrator_top.sv @@
// footstep pose integrator: sequencer, pose state and configuration registers
// a step runs 16 multiplies in turn on the shared 4-bit-digit multiplier, then round,
//   pose update and output load
// a load skips the multiplies and goes from input transfer straight to the output load
// one item at a time: a new input is taken the cycle after the result enters
//   the output register
// reset clears the pose to zero, restores register defaults and empties the output
`default_nettype none

module footstep_pose_integrator_top (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input channel
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic                                    command,
	input  logic signed [fpi_pkg::ACT_W-1:0]        action_forward,
	input  logic signed [fpi_pkg::ACT_W-1:0]        action_lateral,
	input  logic signed [fpi_pkg::ACT_W-1:0]        action_turn,
	input  logic                                    right_support,
	input  logic signed [fpi_pkg::POS_WIDTH-1:0]    load_x,
	input  logic signed [fpi_pkg::POS_WIDTH-1:0]    load_y,
	input  logic [fpi_pkg::YAW_W-1:0]               load_yaw,
	// result channel
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [fpi_pkg::POS_WIDTH-1:0]    pose_x_out,
	output logic signed [fpi_pkg::POS_WIDTH-1:0]    pose_y_out,
	output logic [fpi_pkg::YAW_W-1:0]               yaw_out,
	// configuration write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [fpi_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [fpi_pkg::CFG_DATA_W-1:0]          cfg_data
);
	import fpi_pkg::*;

	localparam int ACC_W = 34;

	// sequencer states
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_POST  = 3'd3;
	localparam logic [2:0] ST_ROUND = 3'd4;
	localparam logic [2:0] ST_POSE  = 3'd5;
	localparam logic [2:0] ST_OUT   = 3'd6;

	// multiply steps of one footstep, in issue order
	localparam logic [3:0] OP_DX  = 4'd0;   // |forward| * scale
	localparam logic [3:0] OP_DY  = 4'd1;   // |lateral| * scale
	localparam logic [3:0] OP_RAD = 4'd2;   // |turn| * scale
	localparam logic [3:0] OP_DTH = 4'd3;   // radians to binary angle
	localparam logic [3:0] OP_SZ2 = 4'd4;   // sine: z*z
	localparam logic [3:0] OP_SC  = 4'd5;   // sine: c*z2
	localparam logic [3:0] OP_ST  = 4'd6;   // sine: t*z2
	localparam logic [3:0] OP_SS  = 4'd7;   // sine: z*t
	localparam logic [3:0] OP_CZ2 = 4'd8;   // cosine, same four steps
	localparam logic [3:0] OP_CC  = 4'd9;
	localparam logic [3:0] OP_CT  = 4'd10;
	localparam logic [3:0] OP_CS  = 4'd11;
	localparam logic [3:0] OP_XC  = 4'd12;  // cos*dx
	localparam logic [3:0] OP_XS  = 4'd13;  // sin*dy
	localparam logic [3:0] OP_YS  = 4'd14;  // sin*dx
	localparam logic [3:0] OP_YC  = 4'd15;  // cos*dy

	localparam logic signed [ACC_W-1:0] RND_POS = ACC_W'(8192);
	localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'(8191);

	// round to nearest, ties away from zero, by 2^14 with a single add
	function automatic logic signed [WX_W-1:0] round_q14(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] adj;
		adj = v + (v[ACC_W-1] ? RND_NEG : RND_POS);
		return adj[ACC_W-1:14];
	endfunction

	// clip a widened pose sum back to the signed pose range
	function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-POS_WIDTH:0] top;
		top = v[SUM_W-1:POS_WIDTH-1];
		if ((&top) || !(|top)) begin
			return v[POS_WIDTH-1:0];
		end else if (v[SUM_W-1]) begin
			return {1'b1, {(POS_WIDTH-1){1'b0}}};
		end else begin
			return {1'b0, {(POS_WIDTH-1){1'b1}}};
		end
	endfunction

	// control
	logic [2:0] state_q;
	logic [3:0] step_q;
	logic       out_valid_q;
	logic       in_xfer;
	logic       out_load;

	// configuration registers
	logic [15:0]       scale_q;
	logic [15:0]       spacing_q;
	logic [15:0]       lim_fwd_q;
	logic [15:0]       lim_bwd_q;
	logic [15:0]       lim_left_q;
	logic [15:0]       lim_right_q;
	logic [TURN_W-1:0] lim_turn_q;

	// pose state
	logic signed [POS_WIDTH-1:0] pose_x_q;
	logic signed [POS_WIDTH-1:0] pose_y_q;
	logic [YAW_W-1:0]            yaw_q;

	// latched step command
	logic [ACT_W-1:0] af_q;
	logic [ACT_W-1:0] al_q;
	logic [ACT_W-1:0] at_q;
	logic             rs_q;

	// intermediate results, sign and magnitude where the sign is cheap to track
	logic [31:0]             res_q;
	logic [15:0]             dx_mag_q;
	logic                    dx_neg_q;
	logic [15:0]             dy_mag_q;
	logic                    dy_neg_q;
	logic [YAW_W-1:0]        dth_q;
	logic [14:0]             z2_q;
	logic [14:0]             t_q;
	logic [15:0]             sin_mag_q;
	logic                    sin_neg_q;
	logic [15:0]             cos_mag_q;
	logic                    cos_neg_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_x_q;
	logic signed [WX_W-1:0]  wx_q;
	logic signed [WX_W-1:0]  wy_q;

	// multiplier interface
	logic                 mul_start;
	logic [MUL_A_W-1:0]   mul_a;
	logic [MUL_B_W-1:0]   mul_b;
	logic                 mul_done;
	logic [MUL_P_W-1:0]   mul_p;

	// combinational helpers
	logic [15:0]             af_mag;
	logic [15:0]             al_mag;
	logic [15:0]             at_mag;
	logic [YAW_W-1:0]        ang;
	logic [14:0]             z;
	logic [31:0]             rnd8;
	logic [45:0]             rnd24;
	logic [31:0]             res_d;
	logic [15:0]             dx_lim;
	logic [15:0]             dx_mag_d;
	logic [23:0]             dy_sum;
	logic [23:0]             dy_fmr;
	logic [23:0]             dy_rmf;
	logic                    dy_fs_ge;
	logic [23:0]             dy_m;
	logic                    dy_n;
	logic [15:0]             dy_mag_d;
	logic [14:0]             dth_mag;
	logic                    dth_neg;
	logic                    term_neg;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] term_s;
	logic signed [SUM_W-1:0] sum_x;
	logic signed [SUM_W-1:0] sum_y;

	assign in_xfer   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// magnitudes of the latched actions
	assign af_mag = af_q[ACT_W-1] ? (~af_q + 16'd1) : af_q;
	assign al_mag = al_q[ACT_W-1] ? (~al_q + 16'd1) : al_q;
	assign at_mag = at_q[ACT_W-1] ? (~at_q + 16'd1) : at_q;

	// sine steps use yaw, cosine steps use yaw plus a quarter turn
	assign ang = yaw_q + {1'b0, step_q[3], 14'd0};
	assign z   = ang[14] ? (Q14_ONE - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};

	// operand select for the step being issued
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			OP_DX: begin
				mul_a = MUL_A_W'(af_mag);
				mul_b = MUL_B_W'(scale_q);
			end
			OP_DY: begin
				mul_a = MUL_A_W'(al_mag);
				mul_b = MUL_B_W'(scale_q);
			end
			OP_RAD: begin
				mul_a = MUL_A_W'(at_mag);
				mul_b = MUL_B_W'(scale_q);
			end
			OP_DTH: begin
				mul_a = res_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(INV_TWO_PI_Q24);
			end
			OP_SZ2, OP_CZ2: begin
				mul_a = MUL_A_W'(z);
				mul_b = MUL_B_W'(z);
			end
			OP_SC, OP_CC: begin
				mul_a = MUL_A_W'(z2_q);
				mul_b = MUL_B_W'(SIN_C);
			end
			OP_ST, OP_CT: begin
				mul_a = MUL_A_W'(t_q);
				mul_b = MUL_B_W'(z2_q);
			end
			OP_SS, OP_CS: begin
				mul_a = MUL_A_W'(z);
				mul_b = MUL_B_W'(t_q);
			end
			OP_XC: begin
				mul_a = MUL_A_W'(cos_mag_q);
				mul_b = MUL_B_W'(dx_mag_q);
			end
			OP_XS: begin
				mul_a = MUL_A_W'(sin_mag_q);
				mul_b = MUL_B_W'(dy_mag_q);
			end
			OP_YS: begin
				mul_a = MUL_A_W'(sin_mag_q);
				mul_b = MUL_B_W'(dx_mag_q);
			end
			OP_YC: begin
				mul_a = MUL_A_W'(cos_mag_q);
				mul_b = MUL_B_W'(dy_mag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_start = (state_q == ST_ISSUE);

	fpi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// product scaling: rounded for the actions and the turn, truncated in the sine, unscaled for the rotation
	assign rnd8  = mul_p[31:0] + 32'd128;
	assign rnd24 = mul_p[45:0] + 46'd8388608;

	always_comb begin
		case (step_q)
			OP_DX, OP_DY, OP_RAD: res_d = 32'(rnd8[31:8]);
			OP_DTH: res_d = 32'(rnd24[45:24]);
			OP_SZ2, OP_SC, OP_ST, OP_SS,
			OP_CZ2, OP_CC, OP_CT, OP_CS: res_d = mul_p[45:14];
			default: res_d = mul_p[31:0];
		endcase
	end

	// forward: clamp the magnitude against the limit of its own direction
	assign dx_lim   = af_q[ACT_W-1] ? lim_bwd_q : lim_fwd_q;
	assign dx_mag_d = (res_q[23:0] > {8'd0, dx_lim}) ? dx_lim : res_q[15:0];

	// lateral: signed add of the spacing done on magnitudes, then clamp and mirror
	assign dy_sum   = res_q[23:0] + {8'd0, spacing_q};
	assign dy_fmr   = {8'd0, spacing_q} - res_q[23:0];
	assign dy_rmf   = res_q[23:0] - {8'd0, spacing_q};
	assign dy_fs_ge = ({8'd0, spacing_q} >= res_q[23:0]);

	always_comb begin
		if (!al_q[ACT_W-1]) begin
			dy_m = dy_sum;
			dy_n = 1'b0;
		end else if (dy_fs_ge) begin
			dy_m = dy_fmr;
			dy_n = 1'b0;
		end else begin
			dy_m = dy_rmf;
			dy_n = 1'b1;
		end
		if (dy_n) begin
			dy_mag_d = (dy_m > {8'd0, lim_right_q}) ? lim_right_q : dy_m[15:0];
		end else begin
			dy_mag_d = (dy_m > {8'd0, lim_left_q}) ? lim_left_q : dy_m[15:0];
		end
	end

	// turn: clamp magnitude, then mirror for a left support
	assign dth_mag = (res_q[21:0] > {7'd0, lim_turn_q}) ? lim_turn_q : res_q[14:0];
	assign dth_neg = at_q[ACT_W-1] ^ ~rs_q;

	// signed rotation terms
	always_comb begin
		case (step_q)
			OP_XC:   term_neg = cos_neg_q ^ dx_neg_q;
			OP_XS:   term_neg = sin_neg_q ^ dy_neg_q;
			OP_YS:   term_neg = sin_neg_q ^ dx_neg_q;
			OP_YC:   term_neg = cos_neg_q ^ dy_neg_q;
			default: term_neg = 1'b0;
		endcase
	end

	assign term   = {2'b00, res_q};
	assign term_s = term_neg ? -term : term;

	// pose sums, widened before saturation
	assign sum_x = SUM_W'(pose_x_q) + SUM_W'(wx_q);
	assign sum_y = SUM_W'(pose_y_q) + SUM_W'(wy_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= OP_DX;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						step_q  <= OP_DX;
						state_q <= command ? ST_OUT : ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (mul_done) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					if (step_q == OP_YC) begin
						state_q <= ST_ROUND;
					end else begin
						step_q  <= step_q + 4'd1;
						state_q <= ST_ISSUE;
					end
				end
				ST_ROUND: state_q <= ST_POSE;
				ST_POSE:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// configuration registers and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q     <= 16'd4096;
			spacing_q   <= 16'd0;
			lim_fwd_q   <= 16'hFFFF;
			lim_bwd_q   <= 16'hFFFF;
			lim_left_q  <= 16'hFFFF;
			lim_right_q <= 16'hFFFF;
			lim_turn_q  <= 15'd16384;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			yaw_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ACTION_SCALE:   scale_q     <= cfg_data;
					REG_FEET_SPACING:   spacing_q   <= cfg_data;
					REG_LIMIT_FORWARD:  lim_fwd_q   <= cfg_data;
					REG_LIMIT_BACKWARD: lim_bwd_q   <= cfg_data;
					REG_LIMIT_LEFT:     lim_left_q  <= cfg_data;
					REG_LIMIT_RIGHT:    lim_right_q <= cfg_data;
					REG_LIMIT_TURN:     lim_turn_q  <= cfg_data[TURN_W-1:0];
					default: ;
				endcase
			end
			if (in_xfer && command) begin
				pose_x_q <= load_x;
				pose_y_q <= load_y;
				yaw_q    <= load_yaw;
			end else if (state_q == ST_POSE) begin
				pose_x_q <= sat_pos(sum_x);
				pose_y_q <= sat_pos(sum_y);
				yaw_q    <= yaw_q + dth_q;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			af_q <= action_forward;
			al_q <= action_lateral;
			at_q <= action_turn;
			rs_q <= right_support;
		end
		if ((state_q == ST_WAIT) && mul_done) begin
			res_q <= res_d;
		end
		if (state_q == ST_POST) begin
			case (step_q)
				OP_DX: begin
					dx_mag_q <= dx_mag_d;
					dx_neg_q <= af_q[ACT_W-1];
				end
				OP_DY: begin
					dy_mag_q <= dy_mag_d;
					dy_neg_q <= dy_n ^ ~rs_q;
				end
				OP_DTH: dth_q <= dth_neg ? -{1'b0, dth_mag} : {1'b0, dth_mag};
				OP_SZ2, OP_CZ2: z2_q <= res_q[14:0];
				OP_SC, OP_CC: t_q <= SIN_B - res_q[14:0];
				OP_ST, OP_CT: t_q <= SIN_A - res_q[14:0];
				OP_SS: begin
					sin_mag_q <= res_q[15:0];
					sin_neg_q <= ang[15];
				end
				OP_CS: begin
					cos_mag_q <= res_q[15:0];
					cos_neg_q <= ang[15];
				end
				OP_XC: acc_q <= term_s;
				OP_XS: acc_x_q <= acc_q - term_s;
				OP_YS: acc_q <= term_s;
				OP_YC: acc_q <= acc_q + term_s;
				default: ;
			endcase
		end
		if (state_q == ST_ROUND) begin
			wx_q <= round_q14(acc_x_q);
			wy_q <= round_q14(acc_q);
		end
		if (out_load) begin
			pose_x_out <= pose_x_q;
			pose_y_out <= pose_y_q;
			yaw_out    <= yaw_q;
		end
	end

	// a multiply only finishes while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_WAIT))
		else $error("multiplier finished outside the wait state");

	// a load goes straight to the output stage
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && command) |=> (state_q == ST_OUT))
		else $error("load did not go to the output stage");

	// rounding only follows the last rotation product
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) |-> (step_q == OP_YC))
		else $error("rounding entered before the last product");

	// heading holds while the sine and cosine steps depend on it
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q != ST_POSE) && !(in_xfer && command)) |=> $stable(yaw_q))
		else $error("heading changed outside a pose update or load");

endmodule

`default_nettype wire

@@ sv/fpi_mul.sv @@
// digit-serial unsigned multiplier, one 4-bit digit of b per cycle
`default_nettype none

module fpi_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [fpi_pkg::MUL_A_W-1:0]   a,
	input  logic [fpi_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [fpi_pkg::MUL_P_W-1:0]   prod
);
	import fpi_pkg::*;

	logic [MUL_A_W-1:0]         a_q;
	logic [MUL_A_W-1:0]         hi_q;
	logic [MUL_B_W-1:0]         lo_q;
	logic [MUL_CNT_W-1:0]       cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [MUL_A_W+DIGIT_W-1:0] pp;
	logic [MUL_A_W+DIGIT_W-1:0] sum;

	// partial product of the low digit, added into the upper half
	assign pp  = {{DIGIT_W{1'b0}}, a_q} * {{MUL_A_W{1'b0}}, lo_q[DIGIT_W-1:0]};
	assign sum = {{DIGIT_W{1'b0}}, hi_q} + pp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + MUL_CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[MUL_A_W+DIGIT_W-1:DIGIT_W];
			lo_q <= {sum[DIGIT_W-1:0], lo_q[MUL_B_W-1:DIGIT_W]};
		end
	end

	assign done = done_q;
	assign prod = {hi_q, lo_q};

endmodule

`default_nettype wire

@@ tb/fpi_tb_pkg.sv @@
// pose predictor and store of expected poses for the footstep pose integrator testbench
package fpi_tb_pkg;
	import fpi_pkg::*;

	localparam logic CMD_STEP = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	// sine polynomial terms in q14, and turn units per radian in q24
	localparam longint POLY_A           = 25736;
	localparam longint POLY_B           = 10512;
	localparam longint POLY_C           = 1160;
	localparam longint TURN_PER_RAD_Q24 = 2670177;

	localparam longint POS_MAX = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
	localparam longint POS_MIN = -POS_MAX - 1;

	localparam logic [YAW_W-1:0] QUARTER_TURN = 16'd16384;

	typedef struct {
		logic                        command;
		logic signed [ACT_W-1:0]     forward;
		logic signed [ACT_W-1:0]     lateral;
		logic signed [ACT_W-1:0]     turn;
		logic                        right_side;
		logic signed [POS_WIDTH-1:0] x;
		logic signed [POS_WIDTH-1:0] y;
		logic [YAW_W-1:0]            yaw;
	} footstep_t;

	typedef struct {
		logic signed [POS_WIDTH-1:0] x;
		logic signed [POS_WIDTH-1:0] y;
		logic [YAW_W-1:0]            yaw;
	} pose_t;

	// shift right with rounding to nearest, ties away from zero
	function automatic longint round_shift(longint v, int k);
		longint mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + (longint'(1) <<< (k - 1))) >>> k;
		return (v < 0) ? -mag : mag;
	endfunction

	function automatic longint bound(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint sine_q14(logic [YAW_W-1:0] ang);
		longint z, z2, t;
		z = ang[13:0];
		if (ang[14]) z = 16384 - z;
		z2 = (z * z) >>> 14;
		t = (POLY_C * z2) >>> 14;
		t = POLY_B - t;
		t = (t * z2) >>> 14;
		t = POLY_A - t;
		t = (z * t) >>> 14;
		return ang[15] ? -t : t;
	endfunction

	class pose_tracker;
		longint           pose_x, pose_y;
		logic [YAW_W-1:0] heading;
		longint           scale, spacing, lim_fwd, lim_bwd, lim_left, lim_right, lim_turn;
		pose_t            expected_poses[$];
		int               errors;

		function new();
			scale     = 4096;
			spacing   = 0;
			lim_fwd   = 65535;
			lim_bwd   = 65535;
			lim_left  = 65535;
			lim_right = 65535;
			lim_turn  = 16384;
			pose_x    = 0;
			pose_y    = 0;
			heading   = '0;
			errors    = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_ACTION_SCALE:   scale     = data;
				REG_FEET_SPACING:   spacing   = data;
				REG_LIMIT_FORWARD:  lim_fwd   = data;
				REG_LIMIT_BACKWARD: lim_bwd   = data;
				REG_LIMIT_LEFT:     lim_left  = data;
				REG_LIMIT_RIGHT:    lim_right = data;
				REG_LIMIT_TURN:     lim_turn  = data[TURN_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_footstep(footstep_t f);
			longint           dx, dy, rad, dth, c, s, wx, wy;
			logic [YAW_W-1:0] quarter;
			pose_t            p;
			if (f.command == CMD_LOAD) begin
				pose_x  = f.x;
				pose_y  = f.y;
				heading = f.yaw;
			end else begin
				dx  = round_shift(longint'(f.forward) * scale, 8);
				dy  = round_shift(longint'(f.lateral) * scale, 8) + spacing;
				rad = round_shift(longint'(f.turn) * scale, 8);
				dth = round_shift(rad * TURN_PER_RAD_Q24, 24);
				dx  = bound(dx, -lim_bwd, lim_fwd);
				dy  = bound(dy, -lim_right, lim_left);
				dth = bound(dth, -lim_turn, lim_turn);
				if (!f.right_side) begin
					dy  = -dy;
					dth = -dth;
				end
				quarter = heading + QUARTER_TURN;
				s  = sine_q14(heading);
				c  = sine_q14(quarter);
				wx = round_shift(c * dx - s * dy, 14);
				wy = round_shift(s * dx + c * dy, 14);
				pose_x  = bound(pose_x + wx, POS_MIN, POS_MAX);
				pose_y  = bound(pose_y + wy, POS_MIN, POS_MAX);
				heading = heading + dth[YAW_W-1:0];
			end
			p.x   = pose_x[POS_WIDTH-1:0];
			p.y   = pose_y[POS_WIDTH-1:0];
			p.yaw = heading;
			expected_poses.insert(expected_poses.size(), p);
		endfunction

		function void check_pose(longint stamp, logic signed [POS_WIDTH-1:0] x,
				logic signed [POS_WIDTH-1:0] y, logic [YAW_W-1:0] yaw);
			pose_t want;
			if (expected_poses.size() == 0) begin
				$display("%0d ns: unexpected pose x=%0d y=%0d yaw=%0d", stamp, x, y, yaw);
				errors++;
				return;
			end
			want = expected_poses.pop_front();
			if (x !== want.x) begin
				$display("%0d ns: pose_x_out expected %0d actual %0d", stamp, want.x, x);
				errors++;
			end
			if (y !== want.y) begin
				$display("%0d ns: pose_y_out expected %0d actual %0d", stamp, want.y, y);
				errors++;
			end
			if (yaw !== want.yaw) begin
				$display("%0d ns: yaw_out expected %0d actual %0d", stamp, want.yaw, yaw);
				errors++;
			end
		endfunction

		function int pending_poses();
			return expected_poses.size();
		endfunction
	endclass

endpackage

@@ tb/tb_footstep_pose_integrator_top.sv @@
// testbench of the footstep pose integrator: directed and random footsteps under changing settings
module tb_footstep_pose_integrator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fpi_pkg::*;
	import fpi_tb_pkg::*;

	// long enough to cover one full step after the last result
	localparam int SETTLE_CYCLES   = 160;
	localparam int TIMEOUT_NS      = 10_000_000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 75;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        command;
	logic signed [ACT_W-1:0]     action_forward;
	logic signed [ACT_W-1:0]     action_lateral;
	logic signed [ACT_W-1:0]     action_turn;
	logic                        right_support;
	logic signed [POS_WIDTH-1:0] load_x;
	logic signed [POS_WIDTH-1:0] load_y;
	logic [YAW_W-1:0]            load_yaw;
	logic                        out_valid;
	logic                        out_ready;
	logic signed [POS_WIDTH-1:0] pose_x_out;
	logic signed [POS_WIDTH-1:0] pose_y_out;
	logic [YAW_W-1:0]            yaw_out;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;

	pose_tracker sb;

	footstep_pose_integrator_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.action_forward (action_forward),
		.action_lateral (action_lateral),
		.action_turn    (action_turn),
		.right_support  (right_support),
		.load_x         (load_x),
		.load_y         (load_y),
		.load_yaw       (load_yaw),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pose_x_out     (pose_x_out),
		.pose_y_out     (pose_y_out),
		.yaw_out        (yaw_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("tb_footstep_pose_integrator_top: errors");
		$finish;
	end

	// ---------------------------------------------------------------- stimulus helpers

	// half of the actions span the whole range, the rest stay within half a unit
	function automatic logic signed [ACT_W-1:0] random_action();
		if ($urandom_range(0, 1))
			return ACT_W'($urandom());
		return ACT_W'(int'($urandom_range(0, 4095)) - 2048);
	endfunction

	// a quarter of the positions sit close to either rail so saturation shows up
	function automatic logic signed [POS_WIDTH-1:0] random_position();
		case ($urandom_range(0, 7))
			0: return POS_WIDTH'(POS_MAX - longint'($urandom_range(0, 70000)));
			1: return POS_WIDTH'(POS_MIN + longint'($urandom_range(0, 70000)));
			default: return POS_WIDTH'($urandom());
		endcase
	endfunction

	function automatic footstep_t random_footstep();
		footstep_t f;
		f.command    = ($urandom_range(0, 99) < 15) ? CMD_LOAD : CMD_STEP;
		f.forward    = random_action();
		f.lateral    = random_action();
		f.turn       = random_action();
		f.right_side = 1'($urandom_range(0, 1));
		f.x          = random_position();
		f.y          = random_position();
		f.yaw        = YAW_W'($urandom());
		return f;
	endfunction

	// step with chosen actions; the load fields carry noise that must be ignored
	function automatic footstep_t make_step(logic signed [ACT_W-1:0] fwd,
			logic signed [ACT_W-1:0] lat, logic signed [ACT_W-1:0] trn, logic rfoot);
		footstep_t f;
		f            = random_footstep();
		f.command    = CMD_STEP;
		f.forward    = fwd;
		f.lateral    = lat;
		f.turn       = trn;
		f.right_side = rfoot;
		return f;
	endfunction

	// load with chosen pose; the action fields carry noise that must be ignored
	function automatic footstep_t make_load(logic signed [POS_WIDTH-1:0] x,
			logic signed [POS_WIDTH-1:0] y, logic [YAW_W-1:0] yaw);
		footstep_t f;
		f         = random_footstep();
		f.command = CMD_LOAD;
		f.x       = x;
		f.y       = y;
		f.yaw     = yaw;
		return f;
	endfunction

	// one input transfer; valid stays high so a following item can go back to back
	task automatic send_item(footstep_t f);
		@(negedge clk);
		in_valid       <= 1'b1;
		command        <= f.command;
		action_forward <= f.forward;
		action_lateral <= f.lateral;
		action_turn    <= f.turn;
		right_support  <= f.right_side;
		load_x         <= f.x;
		load_y         <= f.y;
		load_yaw       <= f.yaw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_footstep(f);
	endtask

	task automatic idle_for(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending, wait for every expected pose, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_poses() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_setting(logic [15:0] scale, logic [15:0] spacing, logic [15:0] fwd,
			logic [15:0] bwd, logic [15:0] left, logic [15:0] right, logic [15:0] turn);
		write_register(REG_ACTION_SCALE, scale);
		write_register(REG_FEET_SPACING, spacing);
		write_register(REG_LIMIT_FORWARD, fwd);
		write_register(REG_LIMIT_BACKWARD, bwd);
		write_register(REG_LIMIT_LEFT, left);
		write_register(REG_LIMIT_RIGHT, right);
		write_register(REG_LIMIT_TURN, turn);
	endtask

	// register value: often an end of its range, otherwise anywhere in it
	function automatic logic [15:0] pick_setting(int hi);
		case ($urandom_range(0, 4))
			0: return 16'd0;
			1: return 16'(hi);
			default: return 16'($urandom_range(0, hi));
		endcase
	endfunction

	// ---------------------------------------------------------------- directed part

	task automatic run_directed();
		// zero step from the reset pose
		send_item(make_step(16'sd0, 16'sd0, 16'sd0, 1'b1));
		// action extremes, each clamped by the default limits
		send_item(make_step(16'sh7FFF, 16'sd0, 16'sd0, 1'b1));
		send_item(make_step(16'sh8000, 16'sd0, 16'sd0, 1'b1));
		send_item(make_step(16'sd0, 16'sh7FFF, 16'sd0, 1'b1));
		// left support mirrors lateral and turn
		send_item(make_step(16'sd0, 16'sh8000, 16'sd0, 1'b0));
		send_item(make_step(16'sd0, 16'sd0, 16'sh7FFF, 1'b1));
		send_item(make_step(16'sd0, 16'sd0, 16'sh8000, 1'b0));
		// pose extremes, then steps that push past the rails
		send_item(make_load(POS_MAX, POS_MIN, 16'hFFFF));
		send_item(make_step(16'sh7FFF, 16'sh8000, 16'sd0, 1'b1));
		send_item(make_load(POS_MIN, POS_MAX, 16'h8000));
		send_item(make_step(16'sh7FFF, 16'sh7FFF, 16'sd0, 1'b0));
		// remaining quadrants of the heading
		send_item(make_load('0, '0, 16'h4000));
		send_item(make_step(16'sd1000, -16'sd700, 16'sd300, 1'b1));
		send_item(make_load(24'sd12345, -24'sd54321, 16'hC000));
		send_item(make_step(-16'sd1500, 16'sd900, -16'sd200, 1'b0));
		// heading wraps upward past the top and downward past zero
		send_item(make_load('0, '0, 16'hFFF0));
		send_item(make_step(16'sd0, 16'sd0, 16'sd40, 1'b1));
		send_item(make_load('0, '0, 16'h000A));
		send_item(make_step(16'sd0, 16'sd0, -16'sd40, 1'b1));
		// all-ones pose load, then a step with noise on the load fields
		send_item(make_load('1, '1, '1));
		send_item(make_step(random_action(), random_action(), random_action(), 1'b0));
	endtask

	// ---------------------------------------------------------------- random part

	// bursts of back-to-back items separated by gaps of varied length, long enough
	// at times to land anywhere inside a step's processing
	task automatic run_random(int count);
		int remaining, burst, gap;
		remaining = count;
		while (remaining > 0) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
			while (burst > 0 && remaining > 0) begin
				send_item(random_footstep());
				burst--;
				remaining--;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: gap = $urandom_range(0, 3);
				5, 6, 7, 8:    gap = $urandom_range(0, 40);
				default:       gap = $urandom_range(0, 200);
			endcase
			if (gap > 0) idle_for(gap);
			// now and then hold off until the block has returned everything
			if ($urandom_range(0, 39) == 0) settle();
		end
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		command        = CMD_STEP;
		action_forward = '0;
		action_lateral = '0;
		action_turn    = '0;
		right_support  = 1'b0;
		load_x         = '0;
		load_y         = '0;
		load_yaw       = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_ACTION_SCALE;
		cfg_data       = '0;
		sb             = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);

		// register defaults after reset
		run_directed();
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				// everything at zero: steps collapse to nothing
				0: apply_setting(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
				// everything at the top of its range
				1: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
						16'd16384);
				default: apply_setting(pick_setting(65535), pick_setting(65535),
						pick_setting(65535), pick_setting(65535), pick_setting(65535),
						pick_setting(65535), pick_setting(16384));
			endcase
			run_random(ITEMS_PER_PHASE);
			settle();
		end

		if (sb.errors == 0 && sb.pending_poses() == 0) begin
			$display("tb_footstep_pose_integrator_top: clean");
		end else begin
			$display("tb_footstep_pose_integrator_top: errors");
		end
		$finish;
	end

	// ---------------------------------------------------------------- result side

	// receiver stalls in modes of random length: always ready, coin flip,
	// mostly ready, and long stalls with rare ready cycles
	initial begin
		int mode, span;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 300);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0:       out_ready <= 1'b1;
					1:       out_ready <= 1'($urandom_range(0, 1));
					2:       out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ($urandom_range(0, 19) == 0);
				endcase
			end
		end
	end

	// every result transfer is checked against the oldest expected pose
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pose($time, pose_x_out, pose_y_out, yaw_out);
	end

endmodule
